### design/assert_macros.svh
// Assertion helpers shared by the checkers of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond at an edge implies conseq at the next edge.
`define KF_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("kalman checker: next-cycle rule violated");

// Check that prop holds at every edge outside reset.
`define KF_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kalman checker: invariant violated");

`endif

### design/kf_pkg.sv
package kf_pkg;

   // operations of the shared arithmetic unit
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_SUB    = 2'd1,
      OP_MUL    = 2'd2,
      OP_MULDIV = 2'd3
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic sat;
   } alu_sts_type;

   // multiplier digit width of the shared unit
   localparam int DIGIT_BITS = 8;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_INIT_EST   = 3'd0,
      CSR_INIT_VAR   = 3'd1,
      CSR_TRANS      = 3'd2,
      CSR_PROC_NOISE = 3'd3,
      CSR_OBS        = 3'd4,
      CSR_MEAS_NOISE = 3'd5
   } csr_idx_type;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // field widths
   localparam int MEAS_BITS     = 32;
   localparam int EST_BITS      = 32;
   localparam int VAR_BITS      = 31;
   localparam int GAIN_BITS     = 32;
   localparam int RSP_DATA_BITS = 96;

   // configuration reset values
   localparam logic signed [31:0] RST_INIT_EST   = 32'sd0;
   localparam logic        [30:0] RST_INIT_VAR   = 31'd65536;
   localparam logic signed [31:0] RST_TRANS      = 32'sd65536;
   localparam logic        [30:0] RST_PROC_NOISE = 31'd655;
   localparam logic signed [31:0] RST_OBS        = 32'sd65536;
   localparam logic        [30:0] RST_MEAS_NOISE = 31'd6554;

endpackage

### design/kf_alu.sv
module kf_alu #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kf_pkg::alu_ctl_type         ctl,
   input  logic signed [WORD_BITS-1:0] opa,
   input  logic signed [WORD_BITS-1:0] opb,
   input  logic signed [WORD_BITS-1:0] opd,
   output kf_pkg::alu_sts_type         sts,
   output logic signed [WORD_BITS-1:0] res
);

   localparam int W   = WORD_BITS;
   localparam int DIG = kf_pkg::DIGIT_BITS;
   localparam int ND  = (W + DIG - 1) / DIG;
   localparam int MBW = ND * DIG;
   localparam int PW  = 2 * W;
   localparam int CW  = $clog2(PW);

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [PW-1:0]       LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_MUL  = 4'b0010,
      A_DIV  = 4'b0100,
      A_FIN  = 4'b1000
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           done_ff, done_in;
   logic           sat_ff, sat_in;
   logic signed [W-1:0] res_ff, res_in;
   logic [W-1:0]   ma_ff, ma_in;
   logic [MBW-1:0] mb_ff, mb_in;
   logic [W-1:0]   den_ff, den_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic           neg_ff, neg_in;
   logic           div_ff, div_in;

   logic [W-1:0]     mag_a, mag_b, mag_d;
   logic signed [W:0] sum_w;
   logic [DIG-1:0]   digit;
   logic [W+DIG-1:0] part;
   logic [W:0]       trial;
   logic             ge;
   logic [PW-1:0]    mres, lim;
   logic             over;

   assign mag_a = opa[W-1] ? (~$unsigned(opa) + W'(1)) : $unsigned(opa);
   assign mag_b = opb[W-1] ? (~$unsigned(opb) + W'(1)) : $unsigned(opb);
   assign mag_d = opd[W-1] ? (~$unsigned(opd) + W'(1)) : $unsigned(opd);

   assign sum_w = (ctl.op == kf_pkg::OP_SUB) ? ((W+1)'(opa) - (W+1)'(opb))
                                             : ((W+1)'(opa) + (W+1)'(opb));

   assign digit = mb_ff[MBW-1 -: DIG];
   assign part  = (W+DIG)'(ma_ff) * (W+DIG)'(digit);

   assign trial = {rem_ff, prod_ff[PW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   assign mres = div_ff ? prod_ff : (prod_ff >> FRAC_BITS);
   assign lim  = LIM_POS + PW'(neg_ff);
   assign over = mres > lim;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      sat_in   = sat_ff;
      res_in   = res_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               if (ctl.op == kf_pkg::OP_ADD || ctl.op == kf_pkg::OP_SUB) begin
                  // saturate the exact sum to the word range
                  done_in = 1'b1;
                  sat_in  = sum_w[W] != sum_w[W-1];
                  res_in  = (sum_w[W] != sum_w[W-1]) ? (sum_w[W] ? WMIN : WMAX)
                                                     : sum_w[W-1:0];
               end else begin
                  ma_in    = mag_a;
                  mb_in    = MBW'(mag_b);
                  den_in   = mag_d;
                  prod_in  = '0;
                  cnt_in   = '0;
                  div_in   = ctl.op == kf_pkg::OP_MULDIV;
                  neg_in   = (opa[W-1] ^ opb[W-1]) ^
                             ((ctl.op == kf_pkg::OP_MULDIV) & opd[W-1]);
                  state_in = A_MUL;
               end
            end
         end
         A_MUL: begin
            // one digit of the multiplier per cycle, most significant first
            prod_in = (prod_ff << DIG) + PW'(part);
            mb_in   = mb_ff << DIG;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ND - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = div_ff ? A_DIV : A_FIN;
            end
         end
         A_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in  = ge ? W'(trial - {1'b0, den_ff}) : trial[W-1:0];
            prod_in = {prod_ff[PW-2:0], ge};
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(PW - 1)) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            done_in  = 1'b1;
            sat_in   = over;
            if (over) begin
               res_in = neg_ff ? WMIN : WMAX;
            end else begin
               res_in = neg_ff ? -$signed(mres[W-1:0]) : $signed(mres[W-1:0]);
            end
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff  <= sat_in;
      res_ff  <= res_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
   end

   assign sts.done = done_ff;
   assign sts.sat  = sat_ff;
   assign res      = res_ff;

endmodule

### design/scalar_kalman_filter_top.sv
// Channel   Dir  Handshake              Contents
// req       in   req_tvalid/req_tready  tdata: measurement; tuser: restart
// rsp       out  rsp_tvalid/rsp_tready  tdata: estimate, variance, gain; tuser: fault
// csr       in   csr_wr_en              csr_addr selects the register, csr_wdata the value
//
// One request runs on the shared arithmetic unit as nine multiplies, one multiply with
// restoring divide and five saturating adds and subtracts, between taking the request
// and handing off the result. A zero innovation variance skips the divide.
// req_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so the next request is taken while rsp waits on rsp_tready, and the
// sequencer holds its next result until that register frees up.
// Reset (synchronous, active high) restores the configuration defaults, estimate 0 and
// variance 65536 (one in Q16.16).
module scalar_kalman_filter_top #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: [31:0] measurement
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [kf_pkg::MEAS_BITS-1:0]            req_tdata,
   // req_tuser: [0] restart
   input  logic                                    req_tuser,
   // rsp_tdata: [31:0] estimate, [62:32] variance, [94:63] gain, [95] zero
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [kf_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   // rsp_tuser: [0] fault
   output logic                                    rsp_tuser,
   input  logic                                    csr_wr_en,
   input  logic [kf_pkg::CSR_ADDR_BITS-1:0]        csr_addr,
   input  logic [kf_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam int W  = WORD_BITS;
   localparam int XW = W + 34;

   localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] WMAX_X = XW'(WMAX);
   localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;

   // the constant one saturates when the fraction fills the word
   localparam logic ONE_SAT = FRAC_BITS >= W - 1;
   localparam logic signed [W-1:0] ONE_W = ONE_SAT ? WMAX : (W'(1) << FRAC_BITS);
   // variance reset value of 65536 (one in Q16.16), clamped for narrow words
   localparam logic signed [W-1:0] P_RST = (W > 17) ? W'(65536) : WMAX;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   // one micro-op per filter equation term
   typedef enum logic [3:0] {
      U_XP  = 4'd0,   // x' = F*x
      U_FP  = 4'd1,   // F*p
      U_FPF = 4'd2,   // (F*p)*F
      U_PP  = 4'd3,   // p' = .. + Q
      U_HX  = 4'd4,   // H*x'
      U_Y   = 4'd5,   // y = z - H*x'
      U_HP  = 4'd6,   // H*p'
      U_HPH = 4'd7,   // (H*p')*H
      U_S   = 4'd8,   // S = .. + R
      U_K   = 4'd9,   // K = p'*H/S
      U_KY  = 4'd10,  // K*y
      U_X   = 4'd11,  // x = x' + K*y
      U_KH  = 4'd12,  // K*H
      U_T   = 4'd13,  // 1 - K*H
      U_P   = 4'd14   // p = (1 - K*H)*p'
   } step_type;

   // configuration registers
   logic signed [31:0] cfg_init_est_ff;
   logic        [30:0] cfg_init_var_ff;
   logic signed [31:0] cfg_trans_ff;
   logic        [30:0] cfg_proc_noise_ff;
   logic signed [31:0] cfg_obs_ff;
   logic        [30:0] cfg_meas_noise_ff;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      flt_ff, flt_in;
   logic signed [W-1:0] x_ff, x_in, p_ff, p_in;
   logic signed [W-1:0] f_ff, f_in, q_ff, q_in, h_ff, h_in, r_ff, r_in, z_ff, z_in;
   logic signed [W-1:0] xp_ff, xp_in, pp_ff, pp_in, y_ff, y_in, k_ff, k_in;
   logic signed [W-1:0] t1_ff, t1_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [kf_pkg::EST_BITS-1:0]  rsp_est_ff, rsp_est_in;
   logic        [kf_pkg::VAR_BITS-1:0]  rsp_var_ff, rsp_var_in;
   logic signed [kf_pkg::GAIN_BITS-1:0] rsp_gain_ff, rsp_gain_in;
   logic rsp_flt_ff, rsp_flt_in;

   kf_pkg::alu_ctl_type alu_ctl;
   kf_pkg::alu_sts_type alu_sts;
   logic signed [W-1:0] alu_a, alu_b, alu_d, alu_res;

   logic [W:0] cl_f, cl_q, cl_h, cl_r, cl_z, cl_xi, cl_pi;

   // clamp a 33-bit signed value to the word range: {changed, value}
   function automatic logic [W:0] clamp_in(input logic signed [32:0] v);
      logic signed [XW-1:0] vx;
      vx = XW'(v);
      if (vx > WMAX_X) begin
         clamp_in = {1'b1, WMAX_X[W-1:0]};
      end else if (vx < WMIN_X) begin
         clamp_in = {1'b1, WMIN_X[W-1:0]};
      end else begin
         clamp_in = {1'b0, vx[W-1:0]};
      end
   endfunction

   assign cl_f  = clamp_in(33'(cfg_trans_ff));
   assign cl_q  = clamp_in($signed({2'b00, cfg_proc_noise_ff}));
   assign cl_h  = clamp_in(33'(cfg_obs_ff));
   assign cl_r  = clamp_in($signed({2'b00, cfg_meas_noise_ff}));
   assign cl_z  = clamp_in(33'($signed(req_tdata)));
   assign cl_xi = clamp_in(33'(cfg_init_est_ff));
   assign cl_pi = clamp_in($signed({2'b00, cfg_init_var_ff}));

   // configuration writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_init_est_ff   <= kf_pkg::RST_INIT_EST;
         cfg_init_var_ff   <= kf_pkg::RST_INIT_VAR;
         cfg_trans_ff      <= kf_pkg::RST_TRANS;
         cfg_proc_noise_ff <= kf_pkg::RST_PROC_NOISE;
         cfg_obs_ff        <= kf_pkg::RST_OBS;
         cfg_meas_noise_ff <= kf_pkg::RST_MEAS_NOISE;
      end else if (csr_wr_en) begin
         case (csr_addr)
            kf_pkg::CSR_INIT_EST:   cfg_init_est_ff   <= $signed(csr_wdata);
            kf_pkg::CSR_INIT_VAR:   cfg_init_var_ff   <= csr_wdata[30:0];
            kf_pkg::CSR_TRANS:      cfg_trans_ff      <= $signed(csr_wdata);
            kf_pkg::CSR_PROC_NOISE: cfg_proc_noise_ff <= csr_wdata[30:0];
            kf_pkg::CSR_OBS:        cfg_obs_ff        <= $signed(csr_wdata);
            kf_pkg::CSR_MEAS_NOISE: cfg_meas_noise_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // operand select for the current micro-op
   always_comb begin
      alu_ctl.start = state_ff == S_ISSUE;
      alu_ctl.op    = kf_pkg::OP_MUL;
      alu_a         = f_ff;
      alu_b         = x_ff;
      alu_d         = t1_ff;
      case (step_ff)
         U_XP:  begin alu_a = f_ff;  alu_b = x_ff;  end
         U_FP:  begin alu_a = f_ff;  alu_b = p_ff;  end
         U_FPF: begin alu_a = t1_ff; alu_b = f_ff;  end
         U_PP:  begin alu_a = t1_ff; alu_b = q_ff;  alu_ctl.op = kf_pkg::OP_ADD; end
         U_HX:  begin alu_a = h_ff;  alu_b = xp_ff; end
         U_Y:   begin alu_a = z_ff;  alu_b = t1_ff; alu_ctl.op = kf_pkg::OP_SUB; end
         U_HP:  begin alu_a = h_ff;  alu_b = pp_ff; end
         U_HPH: begin alu_a = t1_ff; alu_b = h_ff;  end
         U_S:   begin alu_a = t1_ff; alu_b = r_ff;  alu_ctl.op = kf_pkg::OP_ADD; end
         U_K:   begin
            // S sits in t1 here
            alu_a = pp_ff; alu_b = h_ff; alu_d = t1_ff;
            alu_ctl.op = kf_pkg::OP_MULDIV;
         end
         U_KY:  begin alu_a = k_ff;  alu_b = y_ff;  end
         U_X:   begin alu_a = xp_ff; alu_b = t1_ff; alu_ctl.op = kf_pkg::OP_ADD; end
         U_KH:  begin alu_a = k_ff;  alu_b = h_ff;  end
         U_T:   begin alu_a = ONE_W; alu_b = t1_ff; alu_ctl.op = kf_pkg::OP_SUB; end
         U_P:   begin alu_a = t1_ff; alu_b = pp_ff; end
         default: ;
      endcase
   end

   kf_alu #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_alu (
      .clock(clock),
      .reset(reset),
      .ctl  (alu_ctl),
      .opa  (alu_a),
      .opb  (alu_b),
      .opd  (alu_d),
      .sts  (alu_sts),
      .res  (alu_res)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      flt_in      = flt_ff;
      x_in        = x_ff;
      p_in        = p_ff;
      f_in        = f_ff;
      q_in        = q_ff;
      h_in        = h_ff;
      r_in        = r_ff;
      z_in        = z_ff;
      xp_in       = xp_ff;
      pp_in       = pp_ff;
      y_in        = y_ff;
      k_in        = k_ff;
      t1_in       = t1_ff;
      rsp_est_in  = rsp_est_ff;
      rsp_var_in  = rsp_var_ff;
      rsp_gain_in = rsp_gain_ff;
      rsp_flt_in  = rsp_flt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // latch clamped coefficients and measurement, reload on restart
               f_in   = cl_f[W-1:0];
               q_in   = cl_q[W-1:0];
               h_in   = cl_h[W-1:0];
               r_in   = cl_r[W-1:0];
               z_in   = cl_z[W-1:0];
               flt_in = cl_f[W] | cl_q[W] | cl_h[W] | cl_r[W] | cl_z[W];
               if (req_tuser) begin
                  x_in   = cl_xi[W-1:0];
                  p_in   = cl_pi[W-1:0];
                  flt_in = cl_f[W] | cl_q[W] | cl_h[W] | cl_r[W] | cl_z[W] |
                           cl_xi[W] | cl_pi[W];
               end
               step_in  = U_XP;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (alu_sts.done) begin
               flt_in   = flt_ff | alu_sts.sat;
               state_in = S_ISSUE;
               step_in  = step_type'(step_ff + 4'd1);
               case (step_ff)
                  U_XP:  xp_in = alu_res;
                  U_PP:  pp_in = alu_res;
                  U_Y:   y_in  = alu_res;
                  U_S:   begin
                     t1_in = alu_res;
                     if (alu_res == '0) begin
                        // zero S: no gain, skip the divide
                        k_in    = '0;
                        flt_in  = 1'b1;
                        step_in = U_KY;
                     end
                  end
                  U_K:   k_in  = alu_res;
                  U_X:   x_in  = alu_res;
                  U_T:   begin
                     t1_in  = alu_res;
                     flt_in = flt_ff | alu_sts.sat | ONE_SAT;
                  end
                  U_P:   begin
                     // floor a negative variance at zero
                     p_in     = alu_res[W-1] ? '0 : alu_res;
                     flt_in   = flt_ff | alu_sts.sat | alu_res[W-1];
                     state_in = S_OUT;
                  end
                  default: t1_in = alu_res;
               endcase
            end
         end
         S_OUT: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_est_in   = kf_pkg::EST_BITS'(x_ff);
               rsp_var_in   = kf_pkg::VAR_BITS'(p_ff);
               rsp_gain_in  = kf_pkg::GAIN_BITS'(k_ff);
               rsp_flt_in   = flt_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= U_XP;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         p_ff         <= P_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      flt_ff      <= flt_in;
      f_ff        <= f_in;
      q_ff        <= q_in;
      h_ff        <= h_in;
      r_ff        <= r_in;
      z_ff        <= z_in;
      xp_ff       <= xp_in;
      pp_ff       <= pp_in;
      y_ff        <= y_in;
      k_ff        <= k_in;
      t1_ff       <= t1_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_flt_ff  <= rsp_flt_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_gain_ff, rsp_var_ff, rsp_est_ff};
   assign rsp_tuser  = rsp_flt_ff;

endmodule

### design/kf_checker.sv
`include "assert_macros.svh"

module kf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled response stays offered
   `KF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // a stalled response keeps its payload
   `KF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable({rsp_tdata, rsp_tuser}))
   // the sequencer is busy right after taking a request
   `KF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // no fresh response in the cycle after a request is taken
   `KF_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !rsp_tvalid || $past(rsp_tvalid))
   // the padding bit of the response is always zero
   `KF_ASSERT_ALWAYS(a_rsp_pad_zero, clock, reset, !rsp_tvalid || !rsp_tdata[95])

endmodule

bind scalar_kalman_filter_top kf_checker u_kf_checker (.*);

### verif/scalar_kalman_filter_top_test.sv
module scalar_kalman_filter_top_test;
   import kf_pkg::*;

   // Q16.16 in a 32-bit word, matching the block's default parameters
   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   // generous for the slowest legal run of roughly 1625 requests
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD_CYCLES = 2000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_REQUESTS = 200;
   localparam int DRAIN_CYCLES = 200;

   // exact products and quotients fit comfortably in 128 signed bits
   typedef logic signed [127:0] wide_t;

   localparam wide_t WORD_MAX = (128'sd1 <<< (WORD_BITS - 1)) - 128'sd1;
   localparam wide_t WORD_MIN = -(128'sd1 <<< (WORD_BITS - 1));
   localparam wide_t ONE_Q = 128'sd1 <<< FRAC_BITS;

   typedef struct {
      logic [MEAS_BITS-1:0] measurement;
      logic                 restart;
   } kf_request_t;

   typedef struct {
      logic [EST_BITS-1:0]  estimate;
      logic [VAR_BITS-1:0]  variance;
      logic [GAIN_BITS-1:0] gain;
      logic                 fault;
   } kf_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [MEAS_BITS-1:0]     req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // stimulus and expectations
   kf_request_t pending_requests[$];
   kf_result_t  expected_results[$];

   // filter model: register copies and the two state values
   logic [31:0] csr_shadow [0:5];
   wide_t       est_state;
   wide_t       var_state;
   logic        step_fault;

   logic idle_enable = 1'b1;
   logic hold_trigger = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   meas_trend = 0;

   scalar_kalman_filter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // ---------------------------------------------------------------- model arithmetic

   // Clamp to the word range; any clamp raises the step's fault.
   function automatic wide_t clamp_word(wide_t v);
      if (v > WORD_MAX) begin
         step_fault = 1'b1;
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         step_fault = 1'b1;
         return WORD_MIN;
      end
      return v;
   endfunction

   // Fixed-point product: exact, shifted with truncation toward zero, then clamped.
   function automatic wide_t mul_frac(wide_t a, wide_t b);
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] m;
      logic         neg;
      neg = (a < 0) ^ (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb) >> FRAC_BITS;
      return clamp_word(neg ? -$signed(m) : $signed(m));
   endfunction

   // Gain quotient (a*b)/d with the full-precision product, truncated toward zero.
   function automatic wide_t gain_quotient(wide_t a, wide_t b, wide_t d);
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] md;
      logic [127:0] q;
      logic         neg;
      neg = ((a < 0) ^ (b < 0)) ^ (d < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      md = (d < 0) ? -d : d;
      q = (ma * mb) / md;
      return clamp_word(neg ? -$signed(q) : $signed(q));
   endfunction

   function automatic logic is_variance_reg(csr_idx_type idx);
      return idx == CSR_INIT_VAR || idx == CSR_PROC_NOISE || idx == CSR_MEAS_NOISE;
   endfunction

   // One filter step: predict, form innovation and gain, update and store.
   function automatic kf_result_t kalman_step(logic [MEAS_BITS-1:0] meas, logic restart);
      wide_t      f, qn, h, r, z, x, p, xp, pp, y, s, k, t;
      kf_result_t res;
      step_fault = 1'b0;
      f = $signed(csr_shadow[CSR_TRANS]);
      qn = csr_shadow[CSR_PROC_NOISE][30:0];
      h = $signed(csr_shadow[CSR_OBS]);
      r = csr_shadow[CSR_MEAS_NOISE][30:0];
      z = $signed(meas);
      if (restart) begin
         est_state = $signed(csr_shadow[CSR_INIT_EST]);
         var_state = csr_shadow[CSR_INIT_VAR][30:0];
      end
      x = est_state;
      p = var_state;

      xp = mul_frac(f, x);
      pp = clamp_word(mul_frac(mul_frac(f, p), f) + qn);
      y = clamp_word(z - mul_frac(h, xp));
      s = clamp_word(mul_frac(mul_frac(h, pp), h) + r);
      // zero innovation variance: no gain, the prediction stands
      if (s == 0) begin
         step_fault = 1'b1;
         k = 0;
      end else begin
         k = gain_quotient(pp, h, s);
      end
      x = clamp_word(xp + mul_frac(k, y));
      t = clamp_word(ONE_Q - mul_frac(k, h));
      p = mul_frac(t, pp);
      // rounding can push the variance below zero: pin it at zero
      if (p < 0) begin
         step_fault = 1'b1;
         p = 0;
      end
      est_state = x;
      var_state = p;

      res.estimate = x[31:0];
      res.variance = p[30:0];
      res.gain = k[31:0];
      res.fault = step_fault;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Mostly realistic settings, sometimes an extreme or a raw random word.
   function automatic logic [31:0] draw_setting(csr_idx_type idx);
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = is_variance_reg(idx) ? 32'd0 : 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         2: v = $urandom();
         default: begin
            case (idx)
               CSR_INIT_EST:   v = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
               CSR_INIT_VAR:   v = $urandom_range(0, 32'h4_0000);
               CSR_TRANS:      v = 32'h1_0000 + $urandom_range(0, 32'h2000) - 32'h1000;
               CSR_PROC_NOISE: v = $urandom_range(0, 32'h1000);
               CSR_OBS:        v = 32'h1_0000 + $urandom_range(0, 32'h8000) - 32'h4000;
               default:        v = $urandom_range(0, 32'h1_0000);
            endcase
         end
      endcase
      return v;
   endfunction

   // A slowly drifting signal with noise, plus occasional extremes and raw words.
   function automatic logic [31:0] draw_measurement();
      case ($urandom_range(0, 15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: begin
            meas_trend = meas_trend + $urandom_range(0, 2048) - 1024;
            return meas_trend + $urandom_range(0, 32'h1_0000) - 32'h8000;
         end
      endcase
   endfunction

   task automatic program_csr(csr_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      csr_shadow[idx] = is_variance_reg(idx) ? (value & 32'h7FFF_FFFF) : value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_settings(logic [31:0] init_est, logic [31:0] init_var,
                                 logic [31:0] trans, logic [31:0] proc_noise,
                                 logic [31:0] obs, logic [31:0] meas_noise);
      program_csr(CSR_INIT_EST, init_est);
      program_csr(CSR_INIT_VAR, init_var);
      program_csr(CSR_TRANS, trans);
      program_csr(CSR_PROC_NOISE, proc_noise);
      program_csr(CSR_OBS, obs);
      program_csr(CSR_MEAS_NOISE, meas_noise);
   endtask

   task automatic queue_request(logic [31:0] meas, logic restart);
      kf_request_t item;
      item.measurement = meas;
      item.restart = restart;
      pending_requests.push_back(item);
   endtask

   // Poll on the falling edge so the driver and monitor have settled.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (2) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin : drive_requests
      kf_request_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         // predict at acceptance; settings only change while the block is idle
         if (req_tvalid && req_tready)
            expected_results.push_back(kalman_step(req_tdata, req_tuser));

         if (req_tvalid && !req_tready) begin
            // hold the offered request until it is taken
         end else if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0 && idle_enable &&
                      $urandom_range(0, 5) == 0) begin
            // start an idle burst
            req_gap <= $urandom_range(0, 14);
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            item = pending_requests.pop_front();
            req_tdata <= item.measurement;
            req_tuser <= item.restart;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- long receiver stall

   // Count down a long hold-off each time the stimulus flips the trigger.
   always @(posedge clock) begin : long_hold
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- result monitor

   always @(posedge clock) begin : check_results
      kf_result_t               want;
      logic [RSP_DATA_BITS-1:0] got;
      logic                     bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: data %h fault %b", got, rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            bad = got[31:0] !== want.estimate || got[62:32] !== want.variance ||
                  got[94:63] !== want.gain || got[95] !== 1'b0 ||
                  rsp_tuser !== want.fault;
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: est %h/%h var %h/%h gain %h/%h pad 0/%b fault %b/%b",
                           want.estimate, got[31:0], want.variance, got[62:32],
                           want.gain, got[94:63], got[95], want.fault, rsp_tuser);
            end
         end
      end

      if (reset || hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_gap <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : run_test
      csr_shadow[CSR_INIT_EST] = RST_INIT_EST;
      csr_shadow[CSR_INIT_VAR] = {1'b0, RST_INIT_VAR};
      csr_shadow[CSR_TRANS] = RST_TRANS;
      csr_shadow[CSR_PROC_NOISE] = {1'b0, RST_PROC_NOISE};
      csr_shadow[CSR_OBS] = RST_OBS;
      csr_shadow[CSR_MEAS_NOISE] = {1'b0, RST_MEAS_NOISE};
      est_state = 0;
      var_state = ONE_Q;
      step_fault = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: measurement extremes, with and without restart
      queue_request(32'h0000_0000, 1'b0);
      queue_request(32'h7FFF_FFFF, 1'b0);
      queue_request(32'h8000_0000, 1'b0);
      queue_request(32'hFFFF_FFFF, 1'b0);
      queue_request(32'h0001_0000, 1'b1);
      queue_request(32'h8000_0000, 1'b1);
      queue_request(32'h7FFF_FFFF, 1'b1);
      queue_request(32'h0000_0001, 1'b0);
      wait_idle();

      // zero observation and zero measurement noise: innovation variance is zero
      apply_settings(32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      queue_request(32'h0002_0000, 1'b1);
      queue_request(32'h7FFF_FFFF, 1'b0);
      queue_request(32'hFFFE_0000, 1'b0);
      queue_request(32'h8000_0000, 1'b1);
      wait_idle();

      // every register at its top but the observation, at its bottom: saturation everywhere
      apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF);
      queue_request(32'h7FFF_FFFF, 1'b1);
      queue_request(32'h8000_0000, 1'b0);
      queue_request(32'h0000_0000, 1'b0);
      queue_request(32'h1234_5678, 1'b1);
      wait_idle();

      // most negative transition and initial estimate, upper write bit set on a variance register (dropped)
      apply_settings(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0,
                     32'h7FFF_FFFF, 32'h0);
      queue_request(32'h8000_0000, 1'b1);
      queue_request(32'h7FFF_FFFF, 1'b0);
      queue_request(32'h0000_8000, 1'b0);
      wait_idle();

      // tiny variance with no measurement noise: the variance update rounds near zero
      apply_settings(32'h0001_0000, 32'h7, 32'h0001_0000, 32'h0, 32'h0001_8000, 32'h0);
      queue_request(32'h0003_0000, 1'b1);
      queue_request(32'h0002_8000, 1'b0);
      queue_request(32'hFFFF_0000, 1'b0);
      wait_idle();

      // random phases: fresh settings each, restart first so they take effect
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_csr(CSR_INIT_EST, draw_setting(CSR_INIT_EST));
         program_csr(CSR_INIT_VAR, draw_setting(CSR_INIT_VAR));
         program_csr(CSR_TRANS, draw_setting(CSR_TRANS));
         program_csr(CSR_PROC_NOISE, draw_setting(CSR_PROC_NOISE));
         program_csr(CSR_OBS, draw_setting(CSR_OBS));
         program_csr(CSR_MEAS_NOISE, draw_setting(CSR_MEAS_NOISE));
         // one stretch mid-run and the final phase run without idling
         idle_enable <= (phase != 3 && phase != RANDOM_PHASES - 1);
         meas_trend = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
         for (int n = 0; n < PHASE_REQUESTS; n++)
            queue_request(draw_measurement(), n == 0 || $urandom_range(0, 31) == 0);
         // stall the receiver while requests keep coming, so the input backs up
         if (phase == 2)
            hold_trigger <= ~hold_trigger;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
